>>> hdl/estd_pkg.sv
// Shared types and constants for the epoch seconds to calendar date converter.
// Field widths, calendar constants and the fixed-point reciprocals that replace
// division by constants. No dependencies.
package estd_pkg;

   localparam int EPOCH_W  = 32;
   localparam int OFFSET_W = 17;
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;

   // Register stages between an accepted request and its response.
   localparam int PIPE_STAGES = 8;

   typedef logic signed [OFFSET_W-1:0] offset_type;

   localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 17'sd28800;

   // Register map: one register per 32-bit word.
   localparam logic REG_ZONE_OFFSET = 1'b0;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [19:0] MARCH_SHIFT   = 20'd719468;
   localparam logic [19:0] ERA4_START    = 20'd584388;
   localparam logic [19:0] ERA5_START    = 20'd730485;
   localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;
   localparam logic [11:0] YEAR_ERA4     = 12'd1600;
   localparam logic [11:0] YEAR_ERA5     = 12'd2000;

   // Reciprocals ceil(2^k / d) with k = (bits of dividend) + (bits of d), which
   // makes floor(x * r / 2^k) equal to floor(x / d) over the whole dividend range.
   localparam logic [26:0] RECIP_675  = 27'(((64'd1 << 36) + 64'd674) / 64'd675);
   localparam logic [18:0] RECIP_1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
   localparam logic [18:0] RECIP_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
   localparam logic [18:0] RECIP_365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
   localparam logic [9:0]  RECIP_100  = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
   localparam logic [11:0] RECIP_153  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
   localparam logic [11:0] RECIP_5    = 12'(((64'd1 << 14) + 64'd4) / 64'd5);
   localparam logic [17:0] RECIP_3600 = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
   localparam logic [12:0] RECIP_60   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

endpackage

>>> hdl/estd_if.sv
// Valid/ready channel interfaces for the request and response streams.
// Depends on estd_pkg for the field widths.
interface estd_req_if;
   logic                         valid;
   logic                         ready;
   logic [estd_pkg::EPOCH_W-1:0] epoch_seconds;

   modport source(output valid, output epoch_seconds, input ready);
   modport sink(input valid, input epoch_seconds, output ready);
endinterface

interface estd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [estd_pkg::YEAR_W-1:0]   year;
   logic [estd_pkg::MONTH_W-1:0]  month;
   logic [estd_pkg::DAY_W-1:0]    day;
   logic [estd_pkg::HOUR_W-1:0]   hour;
   logic [estd_pkg::MINUTE_W-1:0] minute;

   modport source(output valid, output year, output month, output day, output hour,
                  output minute, input ready);
   modport sink(input valid, input year, input month, input day, input hour,
                input minute, output ready);
endinterface

>>> hdl/estd_pipe.sv
// Eight-stage conversion pipeline from seconds since the epoch to local date and time.
// Depends on estd_pkg and the channel interfaces in estd_if.sv.
module estd_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  estd_pkg::offset_type zone_offset,
   estd_req_if.sink             req,
   estd_rsp_if.source           rsp
);

   logic [estd_pkg::PIPE_STAGES-1:0] vld_ff;
   logic                             advance;

   // Stage 1: offset sum, clamped at zero.
   logic [32:0] s1_sec_ff, s1_sec_in;
   logic signed [33:0] sum_wide;

   // Stage 2: whole days.
   logic [32:0] s2_sec_ff;
   logic [15:0] s2_days_ff, s2_days_in;
   logic [52:0] day_prod;

   // Stage 3: seconds of day, day of era.
   logic [16:0] s3_rem_ff, s3_rem_in;
   logic [17:0] s3_doe_ff, s3_doe_in;
   logic        s3_era_ff, s3_era_in;
   logic [32:0] day_base;
   logic [19:0] z_days;

   // Stage 4: hour, year numerator.
   logic [16:0] s4_rem_ff;
   logic [17:0] s4_doe_ff;
   logic        s4_era_ff;
   logic [4:0]  s4_hour_ff, s4_hour_in;
   logic [17:0] s4_num_ff, s4_num_in;
   logic [36:0] n1_prod, n2_prod;
   logic [34:0] hour_prod;

   // Stage 5: year of era, seconds within the hour.
   logic [17:0] s5_doe_ff;
   logic        s5_era_ff;
   logic [4:0]  s5_hour_ff;
   logic [8:0]  s5_yoe_ff, s5_yoe_in;
   logic [11:0] s5_mrem_ff, s5_mrem_in;
   logic [36:0] yoe_prod;
   logic [16:0] hour_base;

   // Stage 6: minute, day of year.
   logic        s6_era_ff;
   logic [4:0]  s6_hour_ff;
   logic [8:0]  s6_yoe_ff;
   logic [5:0]  s6_min_ff, s6_min_in;
   logic [8:0]  s6_doy_ff, s6_doy_in;
   logic [24:0] min_prod;
   logic [18:0] cent_prod;
   logic [17:0] year_days;

   // Stage 7: March-based month index.
   logic        s7_era_ff;
   logic [4:0]  s7_hour_ff;
   logic [8:0]  s7_yoe_ff;
   logic [5:0]  s7_min_ff;
   logic [8:0]  s7_doy_ff;
   logic [3:0]  s7_mp_ff, s7_mp_in;
   logic [10:0] mp_num;
   logic [22:0] mp_prod;

   // Stage 8: output register.
   logic [estd_pkg::YEAR_W-1:0]   o_year_ff, o_year_in;
   logic [estd_pkg::MONTH_W-1:0]  o_month_ff, o_month_in;
   logic [estd_pkg::DAY_W-1:0]    o_day_ff, o_day_in;
   logic [estd_pkg::HOUR_W-1:0]   o_hour_ff;
   logic [estd_pkg::MINUTE_W-1:0] o_min_ff;
   logic [10:0] ds_num;
   logic [22:0] ds_prod;
   logic [8:0]  month_start;

   // The whole pipeline moves together; it holds only while a response waits.
   assign advance   = !vld_ff[estd_pkg::PIPE_STAGES-1] || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      sum_wide  = $signed({2'b00, req.epoch_seconds}) + 34'(zone_offset);
      s1_sec_in = sum_wide[33] ? 33'd0 : sum_wide[32:0];
   end

   // Dividing by 86400 is a shift by seven and a division by 675.
   always_comb begin
      day_prod   = 53'(s1_sec_ff[32:7]) * 53'(estd_pkg::RECIP_675);
      s2_days_in = day_prod[51:36];
   end

   // Every reachable day count lies in era 4 or era 5 counted from 0000-03-01.
   always_comb begin
      day_base  = 33'(s2_days_ff) * 33'(estd_pkg::SECS_PER_DAY);
      s3_rem_in = 17'(s2_sec_ff - day_base);
      z_days    = 20'(s2_days_ff) + estd_pkg::MARCH_SHIFT;
      s3_era_in = z_days >= estd_pkg::ERA5_START;
      s3_doe_in = 18'(z_days - (s3_era_in ? estd_pkg::ERA5_START : estd_pkg::ERA4_START));
   end

   always_comb begin
      n1_prod    = 37'(s3_doe_ff) * 37'(estd_pkg::RECIP_1460);
      n2_prod    = 37'(s3_doe_ff) * 37'(estd_pkg::RECIP_36524);
      s4_num_in  = s3_doe_ff - 18'(n1_prod[36:29]) + 18'(n2_prod[36:34])
                   - 18'(s3_doe_ff >= estd_pkg::ERA_LAST_DAY);
      hour_prod  = 35'(s3_rem_ff) * 35'(estd_pkg::RECIP_3600);
      s4_hour_in = hour_prod[33:29];
   end

   always_comb begin
      yoe_prod   = 37'(s4_num_ff) * 37'(estd_pkg::RECIP_365);
      s5_yoe_in  = yoe_prod[35:27];
      hour_base  = 17'(s4_hour_ff) * 17'(estd_pkg::SECS_PER_HOUR);
      s5_mrem_in = 12'(s4_rem_ff - hour_base);
   end

   always_comb begin
      min_prod  = 25'(s5_mrem_ff) * 25'(estd_pkg::RECIP_60);
      s6_min_in = min_prod[23:18];
      cent_prod = 19'(s5_yoe_ff) * 19'(estd_pkg::RECIP_100);
      year_days = 18'(s5_yoe_ff) * 18'd365 + 18'(s5_yoe_ff[8:2]) - 18'(cent_prod[18:16]);
      s6_doy_in = 9'(s5_doe_ff - year_days);
   end

   always_comb begin
      mp_num   = 11'(s6_doy_ff) * 11'd5 + 11'd2;
      mp_prod  = 23'(mp_num) * 23'(estd_pkg::RECIP_153);
      s7_mp_in = mp_prod[22:19];
   end

   // Months are counted from March inside the era, so January and February
   // belong to the following calendar year.
   always_comb begin
      ds_num      = 11'(s7_mp_ff) * 11'd153 + 11'd2;
      ds_prod     = 23'(ds_num) * 23'(estd_pkg::RECIP_5);
      month_start = ds_prod[22:14];
      o_day_in    = 5'(s7_doy_ff - month_start + 9'd1);
      o_month_in  = (s7_mp_ff < 4'd10) ? s7_mp_ff + 4'd3 : s7_mp_ff - 4'd9;
      o_year_in   = 12'(s7_yoe_ff) + (s7_era_ff ? estd_pkg::YEAR_ERA5 : estd_pkg::YEAR_ERA4)
                    + 12'(o_month_in <= 4'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[estd_pkg::PIPE_STAGES-2:0], req.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sec_ff  <= s1_sec_in;

         s2_sec_ff  <= s1_sec_ff;
         s2_days_ff <= s2_days_in;

         s3_rem_ff  <= s3_rem_in;
         s3_doe_ff  <= s3_doe_in;
         s3_era_ff  <= s3_era_in;

         s4_rem_ff  <= s3_rem_ff;
         s4_doe_ff  <= s3_doe_ff;
         s4_era_ff  <= s3_era_ff;
         s4_hour_ff <= s4_hour_in;
         s4_num_ff  <= s4_num_in;

         s5_doe_ff  <= s4_doe_ff;
         s5_era_ff  <= s4_era_ff;
         s5_hour_ff <= s4_hour_ff;
         s5_yoe_ff  <= s5_yoe_in;
         s5_mrem_ff <= s5_mrem_in;

         s6_era_ff  <= s5_era_ff;
         s6_hour_ff <= s5_hour_ff;
         s6_yoe_ff  <= s5_yoe_ff;
         s6_min_ff  <= s6_min_in;
         s6_doy_ff  <= s6_doy_in;

         s7_era_ff  <= s6_era_ff;
         s7_hour_ff <= s6_hour_ff;
         s7_yoe_ff  <= s6_yoe_ff;
         s7_min_ff  <= s6_min_ff;
         s7_doy_ff  <= s6_doy_ff;
         s7_mp_ff   <= s7_mp_in;

         o_year_ff  <= o_year_in;
         o_month_ff <= o_month_in;
         o_day_ff   <= o_day_in;
         o_hour_ff  <= s7_hour_ff;
         o_min_ff   <= s7_min_ff;
      end
   end

   assign rsp.valid  = vld_ff[estd_pkg::PIPE_STAGES-1];
   assign rsp.year   = o_year_ff;
   assign rsp.month  = o_month_ff;
   assign rsp.day    = o_day_ff;
   assign rsp.hour   = o_hour_ff;
   assign rsp.minute = o_min_ff;

endmodule

>>> hdl/epoch_seconds_to_date.sv
// Throughput: one request per cycle; the conversion is cut into eight register
// stages, and the whole pipeline holds while a response is stalled.
// Reset (synchronous) empties the pipeline and loads the zone offset with +8 hours.
// Top level: zone offset register on the APB-style port and the conversion pipeline.
// Depends on estd_pkg, estd_if.sv and estd_pipe.
module epoch_seconds_to_date (
   input  logic        clock,
   input  logic        reset,
   estd_req_if.sink    req_chan,
   estd_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   estd_pkg::offset_type zone_offset_ff, zone_offset_in;
   logic                 wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready
                   && (paddr[2] == estd_pkg::REG_ZONE_OFFSET);

   assign zone_offset_in = wr_en ? $signed(pwdata[16:0]) : zone_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_offset_ff <= estd_pkg::OFFSET_RESET;
      end else begin
         zone_offset_ff <= zone_offset_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         estd_pkg::REG_ZONE_OFFSET: prdata = 32'(zone_offset_ff);
         default:                   prdata = 32'd0;
      endcase
   end

   estd_pipe u_pipe (
      .clock       (clock),
      .reset       (reset),
      .zone_offset (zone_offset_ff),
      .req         (req_chan),
      .rsp         (rsp_chan)
   );

endmodule
